@@ rtl/ssp_pkg.sv @@
// shared constants, register indexes and the sharpen kernel for the 3x3 sharpen stream
package ssp_pkg;

   localparam int SAMPLE_W     = 8;
   localparam int MAX_WIDTH    = 1024;
   localparam int MAX_HEIGHT   = 4096;
   localparam int MAX_CHANNELS = 4;
   localparam int MIN_DIM      = 3;

   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int CHAN_REG_W   = 3;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_ADDR_W   = 2;

   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int CHAN_W     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int LINE_DEPTH = MAX_WIDTH * MAX_CHANNELS;
   localparam int ADDR_W     = $clog2(LINE_DEPTH);
   localparam int LINE_W     = 2 * SAMPLE_W;
   localparam int ACC_W      = SAMPLE_W + 4;

   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = WIDTH_REG_W'(512);
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = HEIGHT_REG_W'(512);
   localparam logic [CHAN_REG_W-1:0]   CHAN_RESET   = CHAN_REG_W'(3);

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_IMAGE_WIDTH   = 2'd0,
      CSR_IMAGE_HEIGHT  = 2'd1,
      CSR_CHANNEL_COUNT = 2'd2
   } csr_index_type;

   typedef logic [SAMPLE_W-1:0] sample_type;

   // 5*center minus four neighbors, clipped to the sample range
   function automatic sample_type sharpen(input sample_type centre, input sample_type left,
                                          input sample_type right, input sample_type up,
                                          input sample_type down);
      logic signed [ACC_W-1:0] acc;
      logic signed [ACC_W-1:0] c_ext;
      c_ext = $signed({4'b0000, centre});
      acc = (c_ext <<< 2) + c_ext
            - $signed({4'b0000, left}) - $signed({4'b0000, right})
            - $signed({4'b0000, up}) - $signed({4'b0000, down});
      if (acc < 0) begin
         return '0;
      end else if (acc > $signed(ACC_W'(255))) begin
         return '1;
      end else begin
         return acc[SAMPLE_W-1:0];
      end
   endfunction

endpackage

@@ rtl/ssp_ram.sv @@
// generic single-port-write ram with one registered read port
module ssp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/sharpen_3x3_stream.sv @@
// top level of the streaming 3x3 sharpen filter
//
// usage:
//   req_* carries one 8-bit channel sample per transfer, raster order, channels
//   interleaved; req_tuser marks the first sample of a frame and restarts the
//   row, column and channel counters.
//   rsp_* carries one sharpened sample per transfer; rsp_tlast marks the last
//   result of a frame. samples in the first row or column produce 0; the
//   result for a sample leaves once its lower-right neighbor has arrived, and
//   the last row and column produce no result.
//   csr_* writes image width, image height and channel count; write only when
//   the stream is idle.
// timing: one transfer per cycle sustained while rsp_tready is high; a result
//   reaches rsp through the line store read at the transfer, the kernel stage
//   register and then the output register. both line stores share one 16-bit ram.
// reset: counters, window registers and output valid clear; sizes return to
//   512 x 512 x 3. line stores are not cleared.
// stall: when rsp_tready is low the output register holds, the kernel stage
//   waits behind it and req_tready drops once both are full.
module sharpen_3x3_stream (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [ssp_pkg::SAMPLE_W-1:0]   req_tdata,  // sample
   input  logic                           req_tuser,  // frame_start
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [ssp_pkg::SAMPLE_W-1:0]   rsp_tdata,  // sharpened
   output logic                           rsp_tlast,  // frame_done
   input  logic                           csr_we,
   input  logic [ssp_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [ssp_pkg::CSR_DATA_W-1:0] csr_wdata
);

   // configuration
   logic [ssp_pkg::WIDTH_REG_W-1:0]  width_ff, width_in, w_eff;
   logic [ssp_pkg::HEIGHT_REG_W-1:0] height_ff, height_in, h_eff;
   logic [ssp_pkg::CHAN_REG_W-1:0]   chans_ff, chans_in, nc_eff;

   // position counters
   logic [ssp_pkg::COL_W-1:0]  col_ff, col_in, x_cur;
   logic [ssp_pkg::ROW_W-1:0]  row_ff, row_in, y_cur;
   logic [ssp_pkg::CHAN_W-1:0] chan_ff, chan_in, c_cur;

   logic [ssp_pkg::ADDR_W-1:0]       rd_addr;
   logic [ssp_pkg::CHAN_REG_W-1:0]   chan_inc;
   logic [ssp_pkg::WIDTH_REG_W-1:0]  col_inc;
   logic [ssp_pkg::HEIGHT_REG_W-1:0] row_inc;
   logic                             emit_a, interior_a, last_a;

   // kernel stage
   logic                             b_valid_ff, b_valid_in;
   logic [ssp_pkg::SAMPLE_W-1:0]     b_sample_ff, b_sample_in;
   logic [ssp_pkg::ADDR_W-1:0]       b_addr_ff, b_addr_in;
   logic [ssp_pkg::CHAN_W-1:0]       b_chan_ff, b_chan_in;
   logic                             b_emit_ff, b_emit_in;
   logic                             b_interior_ff, b_interior_in;
   logic                             b_last_ff, b_last_in;
   logic                             b_fwd_ff, b_fwd_in;
   logic [ssp_pkg::LINE_W-1:0]       b_fwd_data_ff, b_fwd_data_in;

   // window registers per channel
   logic [ssp_pkg::SAMPLE_W-1:0] lw0_ff [ssp_pkg::MAX_CHANNELS];
   logic [ssp_pkg::SAMPLE_W-1:0] lw0_in [ssp_pkg::MAX_CHANNELS];
   logic [ssp_pkg::SAMPLE_W-1:0] lw1_ff [ssp_pkg::MAX_CHANNELS];
   logic [ssp_pkg::SAMPLE_W-1:0] lw1_in [ssp_pkg::MAX_CHANNELS];
   logic [ssp_pkg::SAMPLE_W-1:0] uw_ff  [ssp_pkg::MAX_CHANNELS];
   logic [ssp_pkg::SAMPLE_W-1:0] uw_in  [ssp_pkg::MAX_CHANNELS];
   logic [ssp_pkg::SAMPLE_W-1:0] dw_ff  [ssp_pkg::MAX_CHANNELS];
   logic [ssp_pkg::SAMPLE_W-1:0] dw_in  [ssp_pkg::MAX_CHANNELS];

   // output register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [ssp_pkg::SAMPLE_W-1:0] rsp_data_ff, rsp_data_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic                         req_fire, b_fire;
   logic [ssp_pkg::LINE_W-1:0]   ram_q, line_q, wr_data;
   logic [ssp_pkg::SAMPLE_W-1:0] right_b, upper_b;

   assign b_fire     = b_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !b_valid_ff || b_fire;
   assign req_fire   = req_tvalid && req_tready;

   // clamped sizes
   always_comb begin
      w_eff = width_ff;
      if (width_ff < ssp_pkg::WIDTH_REG_W'(ssp_pkg::MIN_DIM)) begin
         w_eff = ssp_pkg::WIDTH_REG_W'(ssp_pkg::MIN_DIM);
      end else if (width_ff > ssp_pkg::WIDTH_REG_W'(ssp_pkg::MAX_WIDTH)) begin
         w_eff = ssp_pkg::WIDTH_REG_W'(ssp_pkg::MAX_WIDTH);
      end
      h_eff = height_ff;
      if (height_ff < ssp_pkg::HEIGHT_REG_W'(ssp_pkg::MIN_DIM)) begin
         h_eff = ssp_pkg::HEIGHT_REG_W'(ssp_pkg::MIN_DIM);
      end else if (height_ff > ssp_pkg::HEIGHT_REG_W'(ssp_pkg::MAX_HEIGHT)) begin
         h_eff = ssp_pkg::HEIGHT_REG_W'(ssp_pkg::MAX_HEIGHT);
      end
      nc_eff = chans_ff;
      if (chans_ff < ssp_pkg::CHAN_REG_W'(1)) begin
         nc_eff = ssp_pkg::CHAN_REG_W'(1);
      end else if (chans_ff > ssp_pkg::CHAN_REG_W'(ssp_pkg::MAX_CHANNELS)) begin
         nc_eff = ssp_pkg::CHAN_REG_W'(ssp_pkg::MAX_CHANNELS);
      end
   end

   // csr writes
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      chans_in  = chans_ff;
      if (csr_we) begin
         case (csr_addr)
            ssp_pkg::CSR_IMAGE_WIDTH: begin
               width_in = csr_wdata[ssp_pkg::WIDTH_REG_W-1:0];
            end
            ssp_pkg::CSR_IMAGE_HEIGHT: begin
               height_in = csr_wdata[ssp_pkg::HEIGHT_REG_W-1:0];
            end
            ssp_pkg::CSR_CHANNEL_COUNT: begin
               chans_in = csr_wdata[ssp_pkg::CHAN_REG_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // position of the incoming sample and counter advance
   always_comb begin
      x_cur = req_tuser ? '0 : col_ff;
      y_cur = req_tuser ? '0 : row_ff;
      c_cur = req_tuser ? '0 : chan_ff;
      rd_addr = ssp_pkg::ADDR_W'(x_cur) * ssp_pkg::ADDR_W'(nc_eff)
                + ssp_pkg::ADDR_W'(c_cur);
      emit_a     = (y_cur != '0) && (x_cur != '0);
      interior_a = (y_cur[ssp_pkg::ROW_W-1:1] != '0) && (x_cur[ssp_pkg::COL_W-1:1] != '0);
      last_a = (ssp_pkg::HEIGHT_REG_W'(y_cur) == h_eff - ssp_pkg::HEIGHT_REG_W'(1))
            && (ssp_pkg::WIDTH_REG_W'(x_cur) == w_eff - ssp_pkg::WIDTH_REG_W'(1))
            && (ssp_pkg::CHAN_REG_W'(c_cur) == nc_eff - ssp_pkg::CHAN_REG_W'(1));
      chan_inc = ssp_pkg::CHAN_REG_W'(c_cur) + ssp_pkg::CHAN_REG_W'(1);
      col_inc  = ssp_pkg::WIDTH_REG_W'(x_cur) + ssp_pkg::WIDTH_REG_W'(1);
      row_inc  = ssp_pkg::HEIGHT_REG_W'(y_cur) + ssp_pkg::HEIGHT_REG_W'(1);

      col_in  = col_ff;
      row_in  = row_ff;
      chan_in = chan_ff;
      if (req_fire) begin
         col_in  = x_cur;
         row_in  = y_cur;
         chan_in = chan_inc[ssp_pkg::CHAN_W-1:0];
         if (chan_inc >= nc_eff) begin
            chan_in = '0;
            col_in  = col_inc[ssp_pkg::COL_W-1:0];
            if (col_inc >= w_eff) begin
               col_in = '0;
               row_in = row_inc[ssp_pkg::ROW_W-1:0];
               if (row_inc >= h_eff) begin
                  row_in = '0;
               end
            end
         end
      end
   end

   // line stores: upper line in the high byte, middle line in the low byte
   assign line_q  = b_fwd_ff ? b_fwd_data_ff : ram_q;
   assign right_b = line_q[ssp_pkg::SAMPLE_W-1:0];
   assign upper_b = line_q[ssp_pkg::LINE_W-1:ssp_pkg::SAMPLE_W];
   assign wr_data = {right_b, b_sample_ff};

   ssp_ram #(
      .WIDTH (ssp_pkg::LINE_W),
      .DEPTH (ssp_pkg::LINE_DEPTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (b_fire),
      .wr_addr (b_addr_ff),
      .wr_data (wr_data),
      .rd_en   (req_fire),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // kernel stage load
   always_comb begin
      b_valid_in    = b_valid_ff;
      b_sample_in   = b_sample_ff;
      b_addr_in     = b_addr_ff;
      b_chan_in     = b_chan_ff;
      b_emit_in     = b_emit_ff;
      b_interior_in = b_interior_ff;
      b_last_in     = b_last_ff;
      b_fwd_in      = b_fwd_ff;
      b_fwd_data_in = b_fwd_data_ff;
      if (b_fire) begin
         b_valid_in = 1'b0;
      end
      if (req_fire) begin
         b_valid_in    = 1'b1;
         b_sample_in   = req_tdata;
         b_addr_in     = rd_addr;
         b_chan_in     = c_cur;
         b_emit_in     = emit_a;
         b_interior_in = interior_a;
         b_last_in     = last_a;
         // same entry written by the stage ahead in this cycle
         b_fwd_in      = b_fire && (b_addr_ff == rd_addr);
         b_fwd_data_in = wr_data;
      end
   end

   // window update and result
   always_comb begin
      lw0_in = lw0_ff;
      lw1_in = lw1_ff;
      uw_in  = uw_ff;
      dw_in  = dw_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (b_fire) begin
         lw1_in[b_chan_ff] = lw0_ff[b_chan_ff];
         lw0_in[b_chan_ff] = right_b;
         uw_in[b_chan_ff]  = upper_b;
         dw_in[b_chan_ff]  = b_sample_ff;
         rsp_valid_in = b_emit_ff;
         rsp_last_in  = b_last_ff;
         rsp_data_in  = '0;
         if (b_interior_ff) begin
            rsp_data_in = ssp_pkg::sharpen(lw0_ff[b_chan_ff], lw1_ff[b_chan_ff], right_b,
                                           uw_ff[b_chan_ff], dw_ff[b_chan_ff]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= ssp_pkg::WIDTH_RESET;
         height_ff    <= ssp_pkg::HEIGHT_RESET;
         chans_ff     <= ssp_pkg::CHAN_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         chan_ff      <= '0;
         b_valid_ff   <= 1'b0;
         b_fwd_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ssp_pkg::MAX_CHANNELS; i++) begin
            lw0_ff[i] <= '0;
            lw1_ff[i] <= '0;
            uw_ff[i]  <= '0;
            dw_ff[i]  <= '0;
         end
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         chans_ff     <= chans_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         chan_ff      <= chan_in;
         b_valid_ff   <= b_valid_in;
         b_fwd_ff     <= b_fwd_in;
         rsp_valid_ff <= rsp_valid_in;
         lw0_ff       <= lw0_in;
         lw1_ff       <= lw1_in;
         uw_ff        <= uw_in;
         dw_ff        <= dw_in;
      end
   end

   always_ff @(posedge clock) begin
      b_sample_ff   <= b_sample_in;
      b_addr_ff     <= b_addr_in;
      b_chan_ff     <= b_chan_in;
      b_emit_ff     <= b_emit_in;
      b_interior_ff <= b_interior_in;
      b_last_ff     <= b_last_in;
      b_fwd_data_ff <= b_fwd_data_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

@@ sim/tb.sv @@
// testbench for sharpen_3x3_stream: raster frames checked against a behavioral sharpen predictor
`timescale 1ns / 100ps

module tb;

   localparam int     HALF_PERIOD   = 6;
   localparam int     SETTLE_CYCLES = 8;
   localparam int     DRAIN_LIMIT   = 5000;
   localparam int     PHASE_ITEMS   = 110;
   localparam int     SAMPLE_MAX    = 2 ** ssp_pkg::SAMPLE_W - 1;
   localparam longint RUN_LIMIT_NS  = 64'd12_000_000;

   typedef struct {
      ssp_pkg::sample_type sample;
      logic                start;
   } raster_item_type;

   typedef struct {
      logic [ssp_pkg::SAMPLE_W-1:0] value;
      logic                         last;
   } sharp_result_type;

   typedef enum {FILL_RANDOM, FILL_CHECKER, FILL_WHITE} fill_kind_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [ssp_pkg::SAMPLE_W-1:0]   req_tdata = '0;
   logic                           req_tuser = 1'b0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [ssp_pkg::SAMPLE_W-1:0]   rsp_tdata;
   logic                           rsp_tlast;
   logic                           csr_we = 1'b0;
   logic [ssp_pkg::CSR_ADDR_W-1:0] csr_addr = '0;
   logic [ssp_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   raster_item_type  raster_q[$];
   sharp_result_type sharp_q[$];
   raster_item_type  staged_item;
   sharp_result_type got_result;
   bit               req_took;
   bit               checker_phase;
   int               queued_total;
   int               errors;
   int               src_idle_pct;
   int               sink_idle_pct;

   // predictor state
   logic [ssp_pkg::WIDTH_REG_W-1:0]  size_width  = ssp_pkg::WIDTH_RESET;
   logic [ssp_pkg::HEIGHT_REG_W-1:0] size_height = ssp_pkg::HEIGHT_RESET;
   logic [ssp_pkg::CHAN_REG_W-1:0]   size_chans  = ssp_pkg::CHAN_RESET;
   bit [ssp_pkg::SAMPLE_W-1:0]       upper_row  [ssp_pkg::LINE_DEPTH];
   bit [ssp_pkg::SAMPLE_W-1:0]       middle_row [ssp_pkg::LINE_DEPTH];
   bit [ssp_pkg::SAMPLE_W-1:0]       centre_taps[2*ssp_pkg::MAX_CHANNELS];
   bit [ssp_pkg::SAMPLE_W-1:0]       upper_tap  [ssp_pkg::MAX_CHANNELS];
   bit [ssp_pkg::SAMPLE_W-1:0]       lower_tap  [ssp_pkg::MAX_CHANNELS];
   int                               col_pos;
   int                               row_pos;
   int                               chan_pos;

   sharpen_3x3_stream i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),  // sample
      .req_tuser  (req_tuser),  // frame_start
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),  // sharpened
      .rsp_tlast  (rsp_tlast),  // frame_done
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #(HALF_PERIOD) clock = ~clock;

   function automatic int bound(int v, int lo, int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic int eff_cols();
      return bound(int'(size_width), ssp_pkg::MIN_DIM, ssp_pkg::MAX_WIDTH);
   endfunction

   function automatic int eff_rows();
      return bound(int'(size_height), ssp_pkg::MIN_DIM, ssp_pkg::MAX_HEIGHT);
   endfunction

   function automatic int eff_chans();
      return bound(int'(size_chans), 1, ssp_pkg::MAX_CHANNELS);
   endfunction

   task automatic advance_raster(ssp_pkg::sample_type s, logic start);
      int                         w, h, nc, x, y, c, p, acc;
      bit [ssp_pkg::SAMPLE_W-1:0] right_tap;
      bit [ssp_pkg::SAMPLE_W-1:0] upper_here;
      sharp_result_type           r;
      w  = eff_cols();
      h  = eff_rows();
      nc = eff_chans();
      if (start) begin
         col_pos  = 0;
         row_pos  = 0;
         chan_pos = 0;
      end
      x = col_pos;
      y = row_pos;
      c = chan_pos;
      p = x * nc + c;
      if (p >= ssp_pkg::LINE_DEPTH) begin
         p = ssp_pkg::LINE_DEPTH - 1;
      end
      right_tap  = middle_row[p];
      upper_here = upper_row[p];
      if (y >= 1 && x >= 1) begin
         r.value = '0;
         if (y >= 2 && x >= 2) begin
            acc = 5 * int'(centre_taps[2*c]) - int'(centre_taps[2*c+1]) - int'(right_tap)
                  - int'(upper_tap[c]) - int'(lower_tap[c]);
            if (acc < 0) begin
               acc = 0;
            end
            if (acc > SAMPLE_MAX) begin
               acc = SAMPLE_MAX;
            end
            r.value = ssp_pkg::sample_type'(acc);
         end
         r.last = (y == h - 1) && (x == w - 1) && (c == nc - 1);
         sharp_q.push_back(r);
      end
      // slot 0 holds the center row one pixel back, slot 1 two pixels back
      centre_taps[2*c+1] = centre_taps[2*c];
      centre_taps[2*c]   = right_tap;
      upper_tap[c]       = upper_here;
      lower_tap[c]       = s;
      upper_row[p]       = right_tap;
      middle_row[p]      = s;
      c++;
      if (c >= nc) begin
         c = 0;
         x++;
         if (x >= w) begin
            x = 0;
            y++;
            if (y >= h) begin
               y = 0;
            end
         end
      end
      chan_pos = c;
      col_pos  = x;
      row_pos  = y;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_took = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (sharp_q.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual sharpened %0d frame_done %0d",
                        $time, rsp_tdata, rsp_tlast);
               errors++;
            end else begin
               got_result = sharp_q.pop_front();
               if (rsp_tdata !== got_result.value) begin
                  $display("%0t: sharpened mismatch, expected %0d actual %0d",
                           $time, got_result.value, rsp_tdata);
                  errors++;
               end
               if (rsp_tlast !== got_result.last) begin
                  $display("%0t: frame_done mismatch, expected %0d actual %0d",
                           $time, got_result.last, rsp_tlast);
                  errors++;
               end
            end
         end
         req_took = req_tvalid && req_tready;
         if (req_took) begin
            advance_raster(req_tdata, req_tuser);
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (!req_tvalid || req_took) begin
            if (raster_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
               staged_item = raster_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= staged_item.sample;
               req_tuser  <= staged_item.start;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
      end
   end

   task automatic write_reg(ssp_pkg::csr_index_type idx, int unsigned value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= ssp_pkg::CSR_DATA_W'(value);
      case (idx)
         ssp_pkg::CSR_IMAGE_WIDTH:   size_width  = ssp_pkg::WIDTH_REG_W'(value);
         ssp_pkg::CSR_IMAGE_HEIGHT:  size_height = ssp_pkg::HEIGHT_REG_W'(value);
         ssp_pkg::CSR_CHANNEL_COUNT: size_chans  = ssp_pkg::CHAN_REG_W'(value);
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic write_sizes(int unsigned w, int unsigned h, int unsigned nc);
      write_reg(ssp_pkg::CSR_IMAGE_WIDTH, w);
      write_reg(ssp_pkg::CSR_IMAGE_HEIGHT, h);
      write_reg(ssp_pkg::CSR_CHANNEL_COUNT, nc);
   endtask

   task automatic push_frame(int count, bit mark_start, fill_kind_type fill);
      int              w, nc, total, x, y;
      raster_item_type item;
      w     = eff_cols();
      nc    = eff_chans();
      total = w * eff_rows() * nc;
      if (count <= 0 || count > total) begin
         count = total;
      end
      for (int i = 0; i < count; i++) begin
         x = (i / nc) % w;
         y = i / (nc * w);
         item.start = mark_start && (i == 0);
         case (fill)
            FILL_CHECKER: item.sample = (((x + y) % 2) == int'(checker_phase)) ?
                                        ssp_pkg::sample_type'(SAMPLE_MAX) : '0;
            FILL_WHITE:   item.sample = ssp_pkg::sample_type'(SAMPLE_MAX);
            default:      item.sample = ssp_pkg::sample_type'($urandom);
         endcase
         raster_q.push_back(item);
      end
      queued_total += count;
   endtask

   task automatic settle();
      int waited;
      waited = 0;
      while (raster_q.size() != 0 || req_tvalid) begin
         @(posedge clock);
      end
      while (sharp_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (sharp_q.size() != 0) begin
         $display("%0t: %0d results missing, expected sharpened %0d frame_done %0d, actual none",
                  $time, sharp_q.size(), sharp_q[0].value, sharp_q[0].last);
         errors++;
         sharp_q.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_phase(int src_pct, int sink_pct, int quota);
      int                     first, total, kind, n;
      ssp_pkg::csr_index_type idx;
      src_idle_pct  = src_pct;
      sink_idle_pct = sink_pct;
      first = queued_total;
      while (queued_total - first < quota) begin
         write_sizes($urandom_range(0, 9), $urandom_range(0, 6), $urandom_range(0, 7));
         n = $urandom_range(1, 3);
         repeat (n) begin
            total = eff_cols() * eff_rows() * eff_chans();
            kind  = $urandom_range(0, 9);
            if (kind < 5) begin
               push_frame(0, 1'b1, FILL_RANDOM);
            end else if (kind == 5) begin
               checker_phase = ~checker_phase;
               push_frame(0, 1'b1, FILL_CHECKER);
            end else if (kind < 8) begin
               // frame cut short by the next frame start
               push_frame($urandom_range(1, total - 1), 1'b1, FILL_RANDOM);
            end else begin
               push_frame(0, 1'b0, FILL_RANDOM);
            end
         end
         settle();
         if ($urandom_range(0, 3) == 0) begin
            // size change in the middle of a frame
            idx = ssp_pkg::csr_index_type'($urandom_range(0, 2));
            case (idx)
               ssp_pkg::CSR_IMAGE_WIDTH:  write_reg(idx, $urandom_range(0, 9));
               ssp_pkg::CSR_IMAGE_HEIGHT: write_reg(idx, $urandom_range(0, 6));
               default:                   write_reg(idx, $urandom_range(0, 7));
            endcase
            push_frame($urandom_range(1, eff_cols() * eff_rows() * eff_chans()), 1'b0,
                       FILL_RANDOM);
            settle();
         end
      end
   endtask

   initial begin
      src_idle_pct  = 37;
      sink_idle_pct = 62;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // sizes left at their reset values, partial first row
      push_frame(48, 1'b1, FILL_RANDOM);
      settle();

      // smallest frame, all sizes below range
      write_sizes(0, 0, 0);
      checker_phase = 1'b0;
      push_frame(0, 1'b1, FILL_CHECKER);
      checker_phase = 1'b1;
      push_frame(0, 1'b0, FILL_CHECKER);
      push_frame(3, 1'b1, FILL_RANDOM);
      push_frame(0, 1'b1, FILL_WHITE);
      settle();

      // full frame with channel count above range
      write_sizes(10, 3, 7);
      push_frame(0, 1'b1, FILL_RANDOM);
      settle();

      // width above range, partial first row
      write_sizes(2047, 3, 4);
      push_frame(40, 1'b1, FILL_RANDOM);
      settle();

      src_idle_pct  = 62;
      sink_idle_pct = 37;
      // height above range, partial frame
      write_sizes(3, 8191, 1);
      push_frame(60, 1'b1, FILL_RANDOM);
      settle();

      // width shrinks below the current column
      write_sizes(5, 4, 2);
      push_frame(17, 1'b1, FILL_RANDOM);
      settle();
      write_reg(ssp_pkg::CSR_IMAGE_WIDTH, 3);
      push_frame(20, 1'b0, FILL_RANDOM);
      settle();
      push_frame(0, 1'b1, FILL_RANDOM);
      settle();

      random_phase(37, 62, PHASE_ITEMS);
      random_phase(62, 37, PHASE_ITEMS);
      random_phase(0, 0, PHASE_ITEMS);
      settle();

      if (errors == 0) begin
         $display("sharpen_3x3_stream test passed");
      end else begin
         $display("sharpen_3x3_stream test failed");
      end
      $finish;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("sharpen_3x3_stream test failed");
      $finish;
   end

endmodule
